FILE: rtl/slab_size_class_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// Slab allocator assertion macros
// Shared property forms for the checker; clock and reset come from the user.
// ----------------------------------------------------------------------------
`ifndef SLAB_SIZE_CLASS_ALLOCATOR_TOP_DEFINES_SVH
`define SLAB_SIZE_CLASS_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define SLAB_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SLAB_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/slab_pkg.sv
// ----------------------------------------------------------------------------
// Slab allocator package
// Word types, status codes and control/status structs shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none
package slab_pkg;
   localparam int NUM_CLASSES_DEF = 8;
   localparam int STACK_DEPTH_DEF = 1024;
   localparam int PAGE_SLOTS_DEF  = 64;
   localparam int ADDR_BITS       = 48;
   localparam int PAGE_BITS       = 36;
   localparam int PAGE_SHIFT      = 12;
   localparam int SIZE_BITS       = 32;
   localparam int CLS_BITS        = 3;
   localparam int MIN_BLOCK       = 16;
   localparam int HEADER_BYTES    = 4;
   localparam int PAGE_BYTES      = 4096;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_ZERO    = 3'd1;
   localparam logic [2:0] ST_LARGE   = 3'd2;
   localparam logic [2:0] ST_NOPAGE  = 3'd3;
   localparam logic [2:0] ST_INVALID = 3'd4;
   localparam logic [2:0] ST_FULL    = 3'd5;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic                   command;
      logic [SIZE_BITS-1:0]   request_size;
      logic [ADDR_BITS-1:0]   block_address;
      logic                   fresh_page_valid;
      logic [PAGE_BITS-1:0]   fresh_page_number;
   } slab_req_type;

   typedef struct packed {
      logic [2:0]             status;
      logic [ADDR_BITS-1:0]   granted_address;
      logic                   page_taken;
   } slab_rsp_type;

   typedef struct packed {
      logic       load;
      logic       lookup;
      logic       set_st;
      logic [2:0] st_code;
      logic       carve_start;
      logic       carve_step;
      logic       pop;
      logic       push;
      logic       emit;
   } slab_cmd_type;

   typedef struct packed {
      logic is_free;
      logic size_zero;
      logic too_large;
      logic cnt_empty;
      logic page_offered;
      logic too_many;
      logic hit;
      logic table_full;
      logic addr_zero;
      logic push_full;
      logic carve_last;
      logic rsp_busy;
   } slab_sts_type;

   // blocks carved from one page: (4096 - 4) / (16 << cls)
   function automatic logic [11:0] carve_count(input logic [CLS_BITS-1:0] cls);
      logic [11:0] avail;
      avail = 12'(PAGE_BYTES - HEADER_BYTES);
      return avail >> ({1'b0, cls} + 4'd4);
   endfunction
endpackage
`default_nettype wire

FILE: rtl/slab_dp.sv
// ----------------------------------------------------------------------------
// Slab allocator datapath
// Request register, class decode, page table, stack counts, stack memory and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module slab_dp #(
   parameter int NUM_CLASSES = slab_pkg::NUM_CLASSES_DEF,
   parameter int STACK_DEPTH = slab_pkg::STACK_DEPTH_DEF,
   parameter int PAGE_SLOTS  = slab_pkg::PAGE_SLOTS_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  slab_pkg::slab_req_type req_data,
   input  slab_pkg::slab_cmd_type cmd,
   output slab_pkg::slab_sts_type sts,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output slab_pkg::slab_rsp_type rsp_data
);
   import slab_pkg::*;

   localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W     = $clog2(STACK_DEPTH);
   localparam int MEM_DEPTH = NUM_CLASSES * STACK_DEPTH;
   localparam int MA_W      = $clog2(MEM_DEPTH);
   localparam int SL_W      = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
   localparam int PG_W      = $clog2(PAGE_SLOTS + 1);
   localparam int CI_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   slab_req_type               req_ff;
   logic [CLS_BITS-1:0]        cls_ff;
   logic [PAGE_SLOTS-1:0]      match_ff;
   logic [CNT_W-1:0]           cnt_ff [NUM_CLASSES];
   logic [PAGE_SLOTS-1:0]      tv_ff;
   logic [PAGE_BITS-1:0]       tpage_ff [PAGE_SLOTS];
   logic [CLS_BITS-1:0]        tcls_ff [PAGE_SLOTS];
   logic [PG_W-1:0]            pages_ff;
   logic [ADDR_BITS-1:0]       acc_ff;
   logic [CNT_W-1:0]           k_ff;
   logic [2:0]                 st_ff;
   logic                       taken_ff;
   logic                       grant_en_ff;
   logic [ADDR_BITS-1:0]       rd_ff;
   logic [ADDR_BITS-1:0]       mem [MEM_DEPTH];
   slab_rsp_type               rsp_ff;
   logic                       rsp_valid_ff;

   logic [CLS_BITS-1:0]        cls_calc;
   logic                       large_calc;
   logic [PAGE_BITS-1:0]       key;
   logic [PAGE_SLOTS-1:0]      match_calc;
   logic [SL_W-1:0]            hit_idx;
   logic [CLS_BITS-1:0]        hit_cls;
   logic [SL_W-1:0]            free_idx;
   logic [CNT_W-1:0]           alloc_cnt;
   logic [CNT_W-1:0]           free_cnt;
   logic [CNT_W-1:0]           top_idx;
   logic [11:0]                n_blk;
   logic [ADDR_BITS-1:0]       base;
   logic [ADDR_BITS-1:0]       size_b;

   function automatic logic [MA_W-1:0] maddr(input logic [CLS_BITS-1:0] c,
                                             input logic [IDX_W-1:0] idx);
      return MA_W'(c) * MA_W'(STACK_DEPTH) + MA_W'(idx);
   endfunction

   always_comb begin
      cls_calc = '0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (req_ff.request_size <= (32'(MIN_BLOCK) << c)) begin
            cls_calc = CLS_BITS'(c);
         end
      end
      large_calc = req_ff.request_size > (32'(MIN_BLOCK) << (NUM_CLASSES - 1));
   end

   assign key = (req_ff.command == CMD_FREE) ? req_ff.block_address[ADDR_BITS-1:PAGE_SHIFT]
                                             : req_ff.fresh_page_number;

   always_comb begin
      hit_idx  = '0;
      hit_cls  = '0;
      free_idx = '0;
      for (int i = 0; i < PAGE_SLOTS; i++) begin
         match_calc[i] = tv_ff[i] && (tpage_ff[i] == key);
         if (match_ff[i]) begin
            hit_idx = hit_idx | SL_W'(i);
            hit_cls = hit_cls | tcls_ff[i];
         end
      end
      for (int i = PAGE_SLOTS - 1; i >= 0; i--) begin
         if (!tv_ff[i]) begin
            free_idx = SL_W'(i);
         end
      end
   end

   assign alloc_cnt = cnt_ff[cls_ff[CI_W-1:0]];
   assign free_cnt  = cnt_ff[hit_cls[CI_W-1:0]];
   assign top_idx   = alloc_cnt - CNT_W'(1);
   assign n_blk     = carve_count(cls_ff);
   assign base      = {req_ff.fresh_page_number, PAGE_SHIFT'(0)} + ADDR_BITS'(HEADER_BYTES);
   assign size_b    = ADDR_BITS'(MIN_BLOCK) << cls_ff;

   always_comb begin
      sts.is_free      = req_ff.command == CMD_FREE;
      sts.size_zero    = req_ff.request_size == '0;
      sts.too_large    = large_calc;
      sts.cnt_empty    = alloc_cnt == '0;
      sts.page_offered = req_ff.fresh_page_valid;
      sts.too_many     = 32'(n_blk) > 32'(STACK_DEPTH);
      sts.hit          = |match_ff;
      sts.table_full   = (pages_ff >= PG_W'(PAGE_SLOTS)) || (&tv_ff);
      sts.addr_zero    = req_ff.block_address == '0;
      sts.push_full    = free_cnt == CNT_W'(STACK_DEPTH);
      sts.carve_last   = (k_ff + CNT_W'(1)) == CNT_W'(n_blk);
      sts.rsp_busy     = rsp_valid_ff && rsp_stall;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.lookup) begin
         cls_ff   <= large_calc ? '0 : cls_calc;
         match_ff <= match_calc;
      end
      if (cmd.set_st) begin
         st_ff <= cmd.st_code;
      end
      if (cmd.carve_start) begin
         acc_ff <= base;
         k_ff   <= '0;
      end else if (cmd.carve_step) begin
         acc_ff <= acc_ff + size_b;
         k_ff   <= k_ff + CNT_W'(1);
      end
      if (cmd.load) begin
         taken_ff    <= 1'b0;
         grant_en_ff <= 1'b0;
      end else begin
         if (cmd.carve_start) taken_ff <= 1'b1;
         if (cmd.pop) grant_en_ff <= 1'b1;
      end
      if (cmd.emit) begin
         rsp_ff.status          <= st_ff;
         rsp_ff.granted_address <= grant_en_ff ? rd_ff : '0;
         rsp_ff.page_taken      <= taken_ff;
      end
   end

   // stack memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.carve_step) begin
         mem[maddr(cls_ff, k_ff[IDX_W-1:0])] <= acc_ff;
      end else if (cmd.push) begin
         mem[maddr(hit_cls, free_cnt[IDX_W-1:0])] <= req_ff.block_address;
      end
      if (cmd.pop) begin
         rd_ff <= mem[maddr(cls_ff, top_idx[IDX_W-1:0])];
      end
   end

   // counts, page table, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) cnt_ff[c] <= '0;
         tv_ff        <= '0;
         pages_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.carve_step && sts.carve_last) begin
            cnt_ff[cls_ff[CI_W-1:0]] <= CNT_W'(n_blk);
         end else if (cmd.pop) begin
            cnt_ff[cls_ff[CI_W-1:0]] <= top_idx;
         end else if (cmd.push) begin
            cnt_ff[hit_cls[CI_W-1:0]] <= free_cnt + CNT_W'(1);
         end
         if (cmd.carve_start) begin
            if (sts.hit) begin
               tcls_ff[hit_idx] <= cls_ff;
            end else begin
               tv_ff[free_idx]    <= 1'b1;
               tpage_ff[free_idx] <= req_ff.fresh_page_number;
               tcls_ff[free_idx]  <= cls_ff;
               pages_ff           <= pages_ff + PG_W'(1);
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

FILE: rtl/slab_ctrl.sv
// ----------------------------------------------------------------------------
// Slab allocator controller
// Sequences lookup, decision, page carving, pop/push and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module slab_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  slab_pkg::slab_sts_type sts,
   output slab_pkg::slab_cmd_type cmd
);
   import slab_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_LOOK   = 6'b000010,
      S_DECIDE = 6'b000100,
      S_CARVE  = 6'b001000,
      S_POP    = 6'b010000,
      S_EMIT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.lookup = 1'b1;
            state_in   = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.set_st = 1'b1;
            state_in   = S_EMIT;
            if (sts.is_free) begin
               if (sts.addr_zero)      cmd.st_code = ST_ZERO;
               else if (!sts.hit)      cmd.st_code = ST_INVALID;
               else if (sts.push_full) cmd.st_code = ST_FULL;
               else begin
                  cmd.st_code = ST_OK;
                  cmd.push    = 1'b1;
               end
            end else begin
               if (sts.size_zero)          cmd.st_code = ST_ZERO;
               else if (sts.too_large)     cmd.st_code = ST_LARGE;
               else if (!sts.cnt_empty) begin
                  cmd.st_code = ST_OK;
                  state_in    = S_POP;
               end else if (!sts.page_offered) cmd.st_code = ST_NOPAGE;
               else if (sts.too_many)          cmd.st_code = ST_FULL;
               else if (!sts.hit && sts.table_full) cmd.st_code = ST_FULL;
               else begin
                  cmd.st_code     = ST_OK;
                  cmd.carve_start = 1'b1;
                  state_in        = S_CARVE;
               end
            end
         end
         S_CARVE: begin
            cmd.carve_step = 1'b1;
            if (sts.carve_last) state_in = S_POP;
         end
         S_POP: begin
            cmd.pop  = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!sts.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign req_stall = state_ff != S_IDLE;
endmodule
`default_nettype wire

FILE: rtl/slab_size_class_allocator_top.sv
// ----------------------------------------------------------------------------
// Slab size-class allocator, top level
// Allocate/free server over power-of-two size classes with on-chip stacks.
// ----------------------------------------------------------------------------
// One request word is handled at a time. A free or any error result passes
// through the lookup and decide states before the emit state registers it in
// the output register. An allocate served from a non-empty class adds a pop
// state, and an allocate that carves a fresh page also adds a carve step for
// each of its n = (4096 - 4) / block size (1 to 255) blocks, since the stack
// memory takes one write per cycle. The emit state waits while a stalled
// result still holds the output register. The next request is taken in the
// cycle after the result is registered. A new request is taken while a
// finished result still waits. No clearing pass follows reset.
`default_nettype none
module slab_size_class_allocator_top #(
   parameter int NUM_CLASSES = slab_pkg::NUM_CLASSES_DEF,
   parameter int STACK_DEPTH = slab_pkg::STACK_DEPTH_DEF,
   parameter int PAGE_SLOTS  = slab_pkg::PAGE_SLOTS_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  slab_pkg::slab_req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output slab_pkg::slab_rsp_type rsp_data
);
   import slab_pkg::*;

   slab_cmd_type cmd;
   slab_sts_type sts;

   slab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   slab_dp #(
      .NUM_CLASSES (NUM_CLASSES),
      .STACK_DEPTH (STACK_DEPTH),
      .PAGE_SLOTS  (PAGE_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire

FILE: rtl/slab_checker.sv
// ----------------------------------------------------------------------------
// Slab allocator port checker
// Watches the result channel of the top level; bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none
`include "slab_size_class_allocator_top_defines.svh"
module slab_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    rsp_valid,
   input wire                    rsp_stall,
   input slab_pkg::slab_rsp_type rsp_data
);
   import slab_pkg::*;

   `SLAB_ASSERT_IMP(a_status_range, rsp_valid, rsp_data.status <= ST_FULL, "bad status code")
   `SLAB_ASSERT_IMP(a_grant_ok, rsp_valid && rsp_data.granted_address != '0, rsp_data.status == ST_OK, "address on failed word")
   `SLAB_ASSERT_IMP(a_taken_ok, rsp_valid && rsp_data.page_taken, rsp_data.status == ST_OK && rsp_data.granted_address != '0, "page taken without grant")
   `SLAB_ASSERT_NXT(a_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled word changed")
endmodule

bind slab_size_class_allocator_top slab_checker u_slab_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab size-class allocator testbench
// Sends allocate and free words, tracks the expected stacks, page table and
// page count in a local model, and checks every result word in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
   import slab_pkg::*;

   localparam int CLASSES = NUM_CLASSES_DEF;
   localparam int DEPTH   = STACK_DEPTH_DEF;
   localparam int SLOTS   = PAGE_SLOTS_DEF;
   localparam int POOL    = 80;
   localparam int STALL_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   slab_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   slab_rsp_type rsp_data;

   slab_size_class_allocator_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // model state
   logic [ADDR_BITS-1:0] free_blocks [CLASSES][DEPTH];
   int                   block_count [CLASSES];
   logic                 slot_valid [SLOTS];
   logic [PAGE_BITS-1:0] slot_page [SLOTS];
   int                   slot_class [SLOTS];
   int                   pages_held;

   slab_req_type pending_words [$];
   slab_rsp_type expected_rsps [$];
   logic [PAGE_BITS-1:0] page_pool [POOL];
   int  send_idle = 0;
   int  recv_idle = 0;
   bit  hold_sender = 1'b0;
   int  errors = 0;
   int  quiet_cycles = 0;

   function automatic int find_slot(logic [PAGE_BITS-1:0] pg);
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && slot_page[i] == pg) return i;
      return -1;
   endfunction

   function automatic logic [2:0] carve_into(int c, logic [PAGE_BITS-1:0] pg);
      int slot;
      int n;
      logic [ADDR_BITS-1:0] base;
      n = (PAGE_BYTES - HEADER_BYTES) / (MIN_BLOCK << c);
      if (n > DEPTH) return ST_FULL;
      slot = find_slot(pg);
      if (slot < 0) begin
         if (pages_held >= SLOTS) return ST_FULL;
         for (int i = 0; i < SLOTS; i++)
            if (!slot_valid[i]) begin
               slot = i;
               break;
            end
         if (slot < 0) return ST_FULL;
         slot_valid[slot] = 1'b1;
         slot_page[slot] = pg;
         pages_held++;
      end
      slot_class[slot] = c;
      base = {pg, 12'(HEADER_BYTES)};
      for (int k = 0; k < n; k++)
         free_blocks[c][k] = base + ADDR_BITS'(k * (MIN_BLOCK << c));
      block_count[c] = n;
      return ST_OK;
   endfunction

   function automatic slab_rsp_type serve_request(slab_req_type r);
      slab_rsp_type o;
      int c;
      int slot;
      logic [ADDR_BITS-1:0] a;
      o = '0;
      o.status = ST_OK;
      if (r.command == CMD_ALLOC) begin
         if (r.request_size == 0) o.status = ST_ZERO;
         else begin
            c = 0;
            while (c < CLASSES && 64'(r.request_size) > 64'(MIN_BLOCK << c)) c++;
            if (c >= CLASSES) o.status = ST_LARGE;
            else begin
               if (block_count[c] == 0) begin
                  if (!r.fresh_page_valid) o.status = ST_NOPAGE;
                  else begin
                     o.status = carve_into(c, r.fresh_page_number);
                     if (o.status == ST_OK) o.page_taken = 1'b1;
                  end
               end
               if (o.status == ST_OK && block_count[c] > 0) begin
                  block_count[c]--;
                  o.granted_address = free_blocks[c][block_count[c]];
               end
            end
         end
      end else begin
         a = r.block_address;
         if (a == 0) o.status = ST_ZERO;
         else begin
            slot = find_slot(a[ADDR_BITS-1:PAGE_SHIFT]);
            if (slot < 0) o.status = ST_INVALID;
            else begin
               c = slot_class[slot];
               if (block_count[c] >= DEPTH) o.status = ST_FULL;
               else begin
                  free_blocks[c][block_count[c]] = a;
                  block_count[c]++;
               end
            end
         end
      end
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_rsps.push_back(serve_request(req_data));
         if (!req_valid || !req_stall) begin
            if (pending_words.size() > 0 && !hold_sender &&
                $urandom_range(99) >= send_idle) begin
               req_data <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h", $time, rsp_data);
               errors++;
            end else if (rsp_data !== expected_rsps[0]) begin
               $display("%0t: mismatch, expected st=%0d addr=%h taken=%b, actual st=%0d addr=%h taken=%b",
                        $time, expected_rsps[0].status, expected_rsps[0].granted_address,
                        expected_rsps[0].page_taken, rsp_data.status,
                        rsp_data.granted_address, rsp_data.page_taken);
               errors++;
               void'(expected_rsps.pop_front());
            end else begin
               void'(expected_rsps.pop_front());
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("slab_size_class_allocator_top regression: fail");
         $finish;
      end
   end

   function automatic slab_req_type make_word(logic cmd, logic [31:0] sz,
                                              logic [ADDR_BITS-1:0] a, logic pv,
                                              logic [PAGE_BITS-1:0] pg);
      slab_req_type w;
      w.command = cmd;
      w.request_size = sz;
      w.block_address = a;
      w.fresh_page_valid = pv;
      w.fresh_page_number = pg;
      return w;
   endfunction

   task automatic add_random_word();
      slab_req_type w;
      int c;
      int pick;
      w.command = 1'($urandom_range(1));
      w.request_size = $urandom();
      w.block_address = ADDR_BITS'({$urandom(), $urandom()});
      w.fresh_page_valid = ($urandom_range(9) < 8);
      w.fresh_page_number = page_pool[$urandom_range(POOL - 1)];
      pick = $urandom_range(99);
      if (pick < 3) w.fresh_page_number = PAGE_BITS'({$urandom(), $urandom()});
      if (w.command == CMD_ALLOC) begin
         c = ($urandom_range(2) == 0) ? CLASSES - 1 : $urandom_range(CLASSES - 1);
         if (pick < 88)
            w.request_size = $urandom_range(MIN_BLOCK << c, (MIN_BLOCK << c) / 2 + 1);
         else if (pick < 92)
            w.request_size = 0;
         else if (pick < 96)
            w.request_size = $urandom_range(32'hFFFF_FFFF, 2049);
      end else if (pick < 90) begin
         w.block_address = {page_pool[$urandom_range(POOL - 1)], 12'($urandom())};
      end else if (pick < 93) begin
         w.block_address = '0;
      end
      pending_words.push_back(w);
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
   endtask

   initial begin
      logic [PAGE_BITS-1:0] pg;
      for (int i = 0; i < POOL; i++) page_pool[i] = PAGE_BITS'({$urandom(), $urandom()});
      for (int c = 0; c < CLASSES; c++) block_count[c] = 0;
      for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
      pages_held = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed
      pg = page_pool[0];
      pending_words.push_back(make_word(CMD_ALLOC, 0, '0, 1'b1, pg));
      pending_words.push_back(make_word(CMD_ALLOC, 32'hFFFF_FFFF, '1, 1'b1, pg));
      pending_words.push_back(make_word(CMD_ALLOC, 2049, '0, 1'b1, pg));
      pending_words.push_back(make_word(CMD_ALLOC, 1, '0, 1'b0, pg));
      pending_words.push_back(make_word(CMD_ALLOC, 1, '0, 1'b1, pg));
      pending_words.push_back(make_word(CMD_ALLOC, 16, '0, 1'b0, '0));
      pending_words.push_back(make_word(CMD_ALLOC, 17, '0, 1'b1, '1));
      pending_words.push_back(make_word(CMD_ALLOC, 2048, '0, 1'b1, '1));
      pending_words.push_back(make_word(CMD_ALLOC, 2048, '0, 1'b1, pg));
      pending_words.push_back(make_word(CMD_ALLOC, 1024, '0, 1'b1, page_pool[1]));
      pending_words.push_back(make_word(CMD_FREE, 0, '0, 1'b0, '0));
      pending_words.push_back(make_word(CMD_FREE, '1, '1, 1'b1, '1));
      pending_words.push_back(make_word(CMD_FREE, 0, {page_pool[2], 12'h004}, 1'b0, '0));
      pending_words.push_back(make_word(CMD_FREE, 0, {pg, 12'hFFF}, 1'b0, '0));
      pending_words.push_back(make_word(CMD_FREE, 0, {pg, 12'h000}, 1'b0, '0));
      pending_words.push_back(make_word(CMD_ALLOC, 100, '0, 1'b0, '0));
      pending_words.push_back(make_word(CMD_ALLOC, 512, '0, 1'b1, page_pool[3]));
      pending_words.push_back(make_word(CMD_ALLOC, 200, '0, 1'b1, page_pool[4]));
      pending_words.push_back(make_word(CMD_ALLOC, 32, '0, 1'b1, page_pool[5]));

      send_idle = 28;
      recv_idle = 69;
      repeat (70) add_random_word();
      drain();

      send_idle = 69;
      recv_idle = 28;
      repeat (35) add_random_word();
      while (pending_words.size() > 0) @(posedge clock);
      // sender pauses until every outstanding result is back
      hold_sender = 1'b1;
      repeat (35) add_random_word();
      while (expected_rsps.size() > 0 || req_valid) @(posedge clock);
      hold_sender = 1'b0;
      drain();

      send_idle = 0;
      recv_idle = 0;
      repeat (70) add_random_word();
      // fill one stack until it overflows
      pg = page_pool[POOL - 1];
      pending_words.push_back(make_word(CMD_ALLOC, 8, '0, 1'b1, pg));
      repeat (780) pending_words.push_back(
         make_word(CMD_FREE, $urandom(), {pg, 12'($urandom())}, 1'b0, '0));
      drain();

      repeat (300) @(posedge clock);
      if (errors == 0)
         $display("slab_size_class_allocator_top regression: pass");
      else
         $display("slab_size_class_allocator_top regression: fail");
      $finish;
   end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/slab_pkg.sv
rtl/slab_dp.sv
rtl/slab_ctrl.sv
rtl/slab_size_class_allocator_top.sv
rtl/slab_checker.sv
test/tb_top.sv
